FILE: hdl/i2cee_pkg.sv
// i2cee_pkg: shared types and constants for the 24Cxx EEPROM byte-access core.
// Used by i2cee_queue, i2cee_engine and i2c_eeprom_byte_access_core.
`timescale 1ns / 1ps

package i2cee_pkg;

  localparam int unsigned I2CEE_QUEUE_DEPTH = 2;

  localparam logic [7:0]  DEV_WRITE_BYTE = 8'hA0;
  localparam logic [7:0]  DEV_READ_BYTE  = 8'hA1;

  localparam logic        RST_WIDE_ADDRESS  = 1'b0;
  localparam logic [15:0] RST_QUARTER       = 16'd40;
  localparam logic [7:0]  RST_POLL_LIMIT    = 8'd250;
  localparam logic [19:0] RST_WRITE_WAIT    = 20'd16000;

  localparam logic [1:0]  REG_WIDE_ADDRESS = 2'd0;
  localparam logic [1:0]  REG_QUARTER      = 2'd1;
  localparam logic [1:0]  REG_POLL_LIMIT   = 2'd2;
  localparam logic [1:0]  REG_WRITE_WAIT   = 2'd3;

  typedef struct packed {
    logic [7:0]  write_data;
    logic [15:0] mem_address;
    logic        sda_in;
    logic        op;
    logic        req_valid;
  } item_t;

  typedef struct packed {
    logic        wide_address;
    logic [15:0] quarter_period;
    logic [7:0]  ack_poll_limit;
    logic [19:0] write_wait_cycles;
  } cfg_t;

  typedef struct packed {
    logic       ack_error;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_enable;
    logic       sda_out;
    logic       scl;
  } result_t;

  typedef enum logic [10:0] {
    PH_IDLE   = 11'b000_0000_0001,
    PH_START  = 11'b000_0000_0010,
    PH_DEV    = 11'b000_0000_0100,
    PH_AHI    = 11'b000_0000_1000,
    PH_ALO    = 11'b000_0001_0000,
    PH_DATA   = 11'b000_0010_0000,
    PH_RSTART = 11'b000_0100_0000,
    PH_DEVRD  = 11'b000_1000_0000,
    PH_RECV   = 11'b001_0000_0000,
    PH_STOP   = 11'b010_0000_0000,
    PH_WWAIT  = 11'b100_0000_0000
  } phase_t;

endpackage

FILE: hdl/i2cee_queue.sv
// i2cee_queue: front end, accepts request/tick items into a short FIFO.
// Depends on i2cee_pkg (item_t).
`timescale 1ns / 1ps

module i2cee_queue
  import i2cee_pkg::*;
#(
  parameter int unsigned DEPTH = I2CEE_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  not_full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t               slot_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  assign not_full  = (count_r != CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: hdl/i2cee_engine.sv
// i2cee_engine: back end, advances the I2C bit sequencer one tick per item
// and registers the bus levels and status. Depends on i2cee_pkg.
`timescale 1ns / 1ps

module i2cee_engine
  import i2cee_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    item_valid,
  input  item_t   item,
  output logic    item_pop,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  quarter_r, quarter_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic [19:0] wait_r, wait_nxt;
  logic [15:0] held_addr_r, held_addr_nxt;
  logic [7:0]  held_data_r, held_data_nxt;
  logic        held_op_r, held_op_nxt;
  logic [7:0]  last_read_r, last_read_nxt;
  logic        ack_failed_r, ack_failed_nxt;
  logic        res_valid_r;
  result_t     res_r, res_nxt;

  logic        step;
  logic        done_c;
  logic        qstep;
  logic        q_adv;
  logic        do_enter;
  phase_t      enter_ph;
  logic [15:0] qp;
  logic [7:0]  page_bits;
  logic        sending;

  assign step      = item_valid && (!res_valid_r || res_ready);
  assign item_pop  = step;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    phase_nxt      = phase_r;
    quarter_nxt    = quarter_r;
    tick_nxt       = tick_r;
    bit_nxt        = bit_r;
    shift_nxt      = shift_r;
    poll_nxt       = poll_r;
    wait_nxt       = wait_r;
    held_addr_nxt  = held_addr_r;
    held_data_nxt  = held_data_r;
    held_op_nxt    = held_op_r;
    last_read_nxt  = last_read_r;
    ack_failed_nxt = ack_failed_r;
    done_c         = 1'b0;
    qstep          = 1'b0;
    q_adv          = 1'b1;
    do_enter       = 1'b0;
    enter_ph       = PH_IDLE;
    qp             = (cfg.quarter_period == '0) ? 16'd1 : cfg.quarter_period;

    if (step) begin
      case (phase_r)
        PH_IDLE: begin
          if (item.req_valid) begin
            held_op_nxt    = item.op;
            held_addr_nxt  = item.mem_address;
            held_data_nxt  = item.write_data;
            ack_failed_nxt = 1'b0;
            tick_nxt       = '0;
            do_enter       = 1'b1;
            enter_ph       = PH_START;
          end
        end
        PH_WWAIT: begin
          if (wait_r == '0) begin
            phase_nxt = PH_IDLE;
            done_c    = 1'b1;
          end else begin
            wait_nxt = wait_r - 1'b1;
          end
        end
        default: begin
          if ({1'b0, tick_r} + 17'd1 >= {1'b0, qp}) begin
            tick_nxt = '0;
            qstep    = 1'b1;
          end else begin
            tick_nxt = tick_r + 1'b1;
          end
        end
      endcase

      if (qstep) begin
        case (phase_r)
          PH_START, PH_RSTART: begin
            if (quarter_r == 2'd3) begin
              do_enter = 1'b1;
              enter_ph = (phase_r == PH_START) ? PH_DEV : PH_DEVRD;
              q_adv    = 1'b0;
            end
          end
          PH_DEV, PH_AHI, PH_ALO, PH_DATA, PH_DEVRD: begin
            if (bit_r < 4'd8) begin
              if (quarter_r == 2'd3) begin
                shift_nxt = {shift_r[6:0], 1'b0};
                bit_nxt   = bit_r + 1'b1;
              end
            end else if (quarter_r == 2'd2) begin
              if (item.sda_in) begin
                q_adv = 1'b0;
                if ({1'b0, poll_r} + 9'd1 > {1'b0, cfg.ack_poll_limit}) begin
                  ack_failed_nxt = 1'b1;
                  do_enter       = 1'b1;
                  enter_ph       = PH_STOP;
                end else begin
                  poll_nxt = poll_r + 1'b1;
                end
              end else begin
                poll_nxt = '0;
              end
            end else if (quarter_r == 2'd3) begin
              do_enter = 1'b1;
              q_adv    = 1'b0;
              case (phase_r)
                PH_DEV:  enter_ph = cfg.wide_address ? PH_AHI : PH_ALO;
                PH_AHI:  enter_ph = PH_ALO;
                PH_ALO:  enter_ph = held_op_r ? PH_DATA : PH_RSTART;
                PH_DATA: enter_ph = PH_STOP;
                default: enter_ph = PH_RECV;
              endcase
            end
          end
          PH_RECV: begin
            if (bit_r < 4'd8 && quarter_r == 2'd1) begin
              shift_nxt = {shift_r[6:0], item.sda_in};
            end
            if (quarter_r == 2'd3) begin
              if (bit_r >= 4'd8) begin
                last_read_nxt = shift_r;
                do_enter      = 1'b1;
                enter_ph      = PH_STOP;
                q_adv         = 1'b0;
              end else begin
                bit_nxt = bit_r + 1'b1;
              end
            end
          end
          PH_STOP: begin
            if (quarter_r == 2'd3) begin
              q_adv       = 1'b0;
              quarter_nxt = '0;
              if (ack_failed_r || !held_op_r) begin
                phase_nxt = PH_IDLE;
                done_c    = 1'b1;
              end else begin
                phase_nxt = PH_WWAIT;
                wait_nxt  = cfg.write_wait_cycles;
              end
            end
          end
          default: q_adv = 1'b1;
        endcase
        if (q_adv) begin
          quarter_nxt = quarter_r + 1'b1;
        end
      end

      if (do_enter) begin
        phase_nxt   = enter_ph;
        quarter_nxt = '0;
        bit_nxt     = '0;
        poll_nxt    = '0;
        page_bits   = cfg.wide_address ? 8'h00 : {4'h0, held_addr_nxt[10:8], 1'b0};
        case (enter_ph)
          PH_DEV:   shift_nxt = DEV_WRITE_BYTE | page_bits;
          PH_AHI:   shift_nxt = held_addr_nxt[15:8];
          PH_ALO:   shift_nxt = held_addr_nxt[7:0];
          PH_DATA:  shift_nxt = held_data_nxt;
          PH_DEVRD: shift_nxt = DEV_READ_BYTE | page_bits;
          PH_RECV:  shift_nxt = '0;
          default:  shift_nxt = shift_nxt;
        endcase
      end else begin
        page_bits = '0;
      end
    end else begin
      page_bits = '0;
    end
  end

  // bus levels and status as seen after this tick
  always_comb begin
    res_nxt.scl        = 1'b1;
    res_nxt.sda_out    = 1'b1;
    res_nxt.sda_enable = 1'b1;
    sending            = 1'b0;
    case (phase_nxt)
      PH_START, PH_RSTART: begin
        res_nxt.scl     = (quarter_nxt == 2'd3) ? 1'b0 :
                          ((quarter_nxt == 2'd0) ? (phase_nxt == PH_START) : 1'b1);
        res_nxt.sda_out = (quarter_nxt < 2'd2);
      end
      PH_DEV, PH_AHI, PH_ALO, PH_DATA, PH_DEVRD, PH_RECV: begin
        sending     = (phase_nxt != PH_RECV);
        res_nxt.scl = (quarter_nxt == 2'd1) || (quarter_nxt == 2'd2);
        if (bit_nxt < 4'd8) begin
          res_nxt.sda_enable = sending;
          res_nxt.sda_out    = sending & shift_nxt[7];
        end else begin
          res_nxt.sda_enable = !sending;
          res_nxt.sda_out    = !sending;
        end
      end
      PH_STOP: begin
        res_nxt.scl     = (quarter_nxt != 2'd0);
        res_nxt.sda_out = (quarter_nxt >= 2'd2);
      end
      default: begin
        res_nxt.scl = 1'b1;
      end
    endcase
    res_nxt.busy_res  = (phase_nxt != PH_IDLE);
    res_nxt.done_res  = done_c;
    res_nxt.read_data = last_read_nxt;
    res_nxt.ack_error = done_c & ack_failed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      quarter_r    <= '0;
      tick_r       <= '0;
      bit_r        <= '0;
      shift_r      <= '0;
      poll_r       <= '0;
      wait_r       <= '0;
      held_addr_r  <= '0;
      held_data_r  <= '0;
      held_op_r    <= 1'b0;
      last_read_r  <= '0;
      ack_failed_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      quarter_r    <= quarter_nxt;
      tick_r       <= tick_nxt;
      bit_r        <= bit_nxt;
      shift_r      <= shift_nxt;
      poll_r       <= poll_nxt;
      wait_r       <= wait_nxt;
      held_addr_r  <= held_addr_nxt;
      held_data_r  <= held_data_nxt;
      held_op_r    <= held_op_nxt;
      last_read_r  <= last_read_nxt;
      ack_failed_r <= ack_failed_nxt;
      if (step) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: hdl/i2c_eeprom_byte_access_core.sv
// i2c_eeprom_byte_access_core: top level, configuration registers, front queue
// and back-end sequencer. Depends on i2cee_pkg, i2cee_queue, i2cee_engine.
`timescale 1ns / 1ps

// Usage
//   Each input request is one clock tick of the I2C master: the request
//   fields (req_valid, op, address, data) plus the sampled SDA level.
//   Every accepted request yields exactly one result carrying the SCL level,
//   SDA drive, busy, done pulse, last read byte and acknowledge error.
//   Configuration (address mode, quarter period, poll limit, write wait) is
//   to be written by the user on the cfg_ channel only while no tick is in
//   flight; the block itself does not enforce it. cfg_ready is always high.
//   A request is first written into the front queue, and the back end then
//   registers its result. Throughput: one request per cycle while out_tready
//   does not stall, set by the sequencer step in the back end.
//   A stalled out_tready holds the registered result; the front queue keeps
//   taking requests until its QUEUE_DEPTH entries are full, then drops
//   in_tready.
//   Reset: synchronous active-low rst_n empties the queue, returns the
//   sequencer to idle and loads the configuration defaults.

module i2c_eeprom_byte_access_core
  import i2cee_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = I2CEE_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // req_valid, mem_address[15:0], write_data[7:0], sda_in
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // scl, sda_out, sda_enable, busy_res, done_res,
                                  // read_data[7:0], ack_error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  cfg_t    cfg_r;
  item_t   in_item;
  item_t   head_item;
  logic    q_not_full;
  logic    q_not_empty;
  logic    q_pop;
  result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wide_address      <= RST_WIDE_ADDRESS;
      cfg_r.quarter_period    <= RST_QUARTER;
      cfg_r.ack_poll_limit    <= RST_POLL_LIMIT;
      cfg_r.write_wait_cycles <= RST_WRITE_WAIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDE_ADDRESS: cfg_r.wide_address      <= cfg_data[0];
        REG_QUARTER:      cfg_r.quarter_period    <= cfg_data[15:0];
        REG_POLL_LIMIT:   cfg_r.ack_poll_limit    <= cfg_data[7:0];
        REG_WRITE_WAIT:   cfg_r.write_wait_cycles <= cfg_data;
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  assign in_item.req_valid   = in_tdata[0];
  assign in_item.mem_address = in_tdata[16:1];
  assign in_item.write_data  = in_tdata[24:17];
  assign in_item.sda_in      = in_tdata[25];
  assign in_item.op          = in_tuser;

  assign in_tready = q_not_full;

  i2cee_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_tvalid && q_not_full),
    .push_item(in_item),
    .not_full (q_not_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head_item(head_item)
  );

  i2cee_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .item_valid(q_not_empty),
    .item      (head_item),
    .item_pop  (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {2'b00, res};

endmodule
